[hdl/coalesced_hash_table_top_assert.svh]
// Assertion macros for the coalesced hash table
`ifndef COALESCED_HASH_TABLE_TOP_ASSERT_SVH
`define COALESCED_HASH_TABLE_TOP_ASSERT_SVH

// hold c in the same cycle whenever a holds
`define CHT_IMPLY(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);

// hold c in the cycle after a holds
`define CHT_NEXT(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);

`endif

[hdl/cht_pkg.sv]
// Shared action and status codes for the coalesced hash table
package cht_pkg;

  localparam logic [1:0] ACT_GET    = 2'd0;
  localparam logic [1:0] ACT_SET    = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;
  localparam logic [1:0] ACT_READ   = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_RANGE    = 2'd3;

  localparam int HASH_WIDTH = 32;
  localparam int MOD_BITS   = 4;

endpackage

[hdl/coalesced_hash_table_top.sv]
// Coalesced hash table top level: sequencer around bucket and entry memories
//
// One request enters on in_valid/in_stall with action, key, hash, value and
// position; one result leaves on out_valid/out_stall with status, inserted,
// out_key, out_value and entry_count. The caller hashes the key.
// A request is taken in the idle cycle. Then the hash is reduced modulo
// CAPACITY, 4 bits a cycle, and the chain walk reads, per link visited, the
// bucket, then the entry. Last, the result is loaded into the output register.
// A set that needs a free bucket adds a downward free scan over the buckets,
// a walk of the chain it appends to, and up to three bucket writes. A remove
// adds the unlink (S_U1, then S_U2 or S_U3 or neither, then S_UC), and, when
// the last entry moves, first reads that entry, walks its chain and moves it.
// Each memory has a single read port with registered read data. A read by
// position reads the entry at that position; in_stall stays high until its
// result is loaded, so the next request is taken only after that.
// After reset the bucket memory is cleared one entry a cycle, all CAPACITY
// entries, with in_stall high. A result waits in the output register while
// out_stall is high; the next request is taken meanwhile, and finishes only
// once the output register is free.
module coalesced_hash_table_top #(
  parameter int CAPACITY    = 64,
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       action,
  input  logic [KEY_WIDTH-1:0]             key,
  input  logic [cht_pkg::HASH_WIDTH-1:0]   hash,
  input  logic [VALUE_WIDTH-1:0]           value,
  input  logic [$clog2(CAPACITY+1)-1:0]    position,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       status,
  output logic                             inserted,
  output logic [KEY_WIDTH-1:0]             out_key,
  output logic [VALUE_WIDTH-1:0]           out_value,
  output logic [$clog2(CAPACITY+1)-1:0]    entry_count
);

  localparam int BW  = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY+1);
  localparam int EW  = KEY_WIDTH + VALUE_WIDTH + BW;
  localparam int MODSTEPS = cht_pkg::HASH_WIDTH / cht_pkg::MOD_BITS;
  localparam int MCW = $clog2(MODSTEPS);

  typedef logic [BW-1:0] bidx_t;
  typedef logic [CW-1:0] cnt_t;
  typedef logic [BW:0]   rem_t;

  localparam logic [4:0] S_CLR  = 5'd0;
  localparam logic [4:0] S_IDLE = 5'd1;
  localparam logic [4:0] S_MOD  = 5'd2;
  localparam logic [4:0] S_LB   = 5'd3;
  localparam logic [4:0] S_LE   = 5'd4;
  localparam logic [4:0] S_RD   = 5'd5;
  localparam logic [4:0] S_RL   = 5'd6;
  localparam logic [4:0] S_RW   = 5'd7;
  localparam logic [4:0] S_RC   = 5'd8;
  localparam logic [4:0] S_U1   = 5'd9;
  localparam logic [4:0] S_U2   = 5'd10;
  localparam logic [4:0] S_U3   = 5'd11;
  localparam logic [4:0] S_UC   = 5'd12;
  localparam logic [4:0] S_PH   = 5'd13;
  localparam logic [4:0] S_FS   = 5'd14;
  localparam logic [4:0] S_PO   = 5'd15;
  localparam logic [4:0] S_PW   = 5'd16;
  localparam logic [4:0] S_P2   = 5'd17;
  localparam logic [4:0] S_P3   = 5'd18;
  localparam logic [4:0] S_FIN  = 5'd19;

  localparam cnt_t CAP_C   = cnt_t'(CAPACITY);
  localparam cnt_t CAPM1_C = cnt_t'(CAPACITY - 1);

  logic [4:0] st, st_next;
  bidx_t clr, clr_next;
  logic [cht_pkg::HASH_WIDTH-1:0] hsh, hsh_next;
  rem_t rem, rem_next;
  logic [MCW-1:0] mc, mc_next;
  logic [1:0] act, act_next;
  logic [KEY_WIDTH-1:0] k, k_next;
  logic [VALUE_WIDTH-1:0] v, v_next;
  cnt_t posr, posr_next;
  bidx_t home, home_next;
  cnt_t cnt, cnt_next;
  cnt_t fp, fp_next;
  bidx_t cur, cur_next;
  bidx_t at, at_next;
  cnt_t prv, prv_next;
  cnt_t e, e_next;
  cnt_t n, n_next;
  cnt_t steps, steps_next;
  cnt_t he, he_next;
  cnt_t hn, hn_next;
  cnt_t slot, slot_next;
  logic diff, diff_next;
  logic [EW-1:0] last_ent, last_ent_next;
  logic [1:0] stat, stat_next;
  logic ins, ins_next;
  logic [KEY_WIDTH-1:0] ok, ok_next;
  logic [VALUE_WIDTH-1:0] ov, ov_next;
  logic ovalid, ovalid_next;
  logic [1:0] status_next;
  logic inserted_next;
  logic [KEY_WIDTH-1:0] out_key_next;
  logic [VALUE_WIDTH-1:0] out_value_next;
  cnt_t entry_count_next;

  logic b_we, e_we;
  bidx_t b_wa, b_ra, e_wa, e_ra;
  logic [2*CW-1:0] b_wd, b_rd;
  logic [EW-1:0] e_wd, e_rd;

  cnt_t rb_ent, rb_nxt;
  logic [KEY_WIDTH-1:0] re_key;
  logic [VALUE_WIDTH-1:0] re_val;
  bidx_t re_home;
  rem_t mod_r;
  logic accept;

  assign rb_ent  = b_rd[2*CW-1:CW];
  assign rb_nxt  = b_rd[CW-1:0];
  assign re_key  = e_rd[EW-1 -: KEY_WIDTH];
  assign re_val  = e_rd[BW +: VALUE_WIDTH];
  assign re_home = e_rd[BW-1:0];

  assign in_stall = (st != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_valid = ovalid;

  cht_ram #(.WIDTH(2*CW), .DEPTH(CAPACITY)) u_bucket_ram (
    .clk(clk), .we(b_we), .waddr(b_wa), .wdata(b_wd), .raddr(b_ra), .rdata(b_rd)
  );

  cht_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_entry_ram (
    .clk(clk), .we(e_we), .waddr(e_wa), .wdata(e_wd), .raddr(e_ra), .rdata(e_rd)
  );

  always_comb begin
    mod_r = rem;
    for (int j = 0; j < cht_pkg::MOD_BITS; j++) begin
      mod_r = {mod_r[BW-1:0], hsh[cht_pkg::HASH_WIDTH-1-j]};
      if (mod_r >= rem_t'(CAPACITY)) begin
        mod_r = mod_r - rem_t'(CAPACITY);
      end
    end
  end

  always_comb begin
    st_next = st; clr_next = clr; hsh_next = hsh; rem_next = rem; mc_next = mc;
    act_next = act; k_next = k; v_next = v; posr_next = posr; home_next = home;
    cnt_next = cnt; fp_next = fp; cur_next = cur; at_next = at; prv_next = prv;
    e_next = e; n_next = n; steps_next = steps; he_next = he; hn_next = hn;
    slot_next = slot; diff_next = diff; last_ent_next = last_ent;
    stat_next = stat; ins_next = ins; ok_next = ok; ov_next = ov;
    ovalid_next = ovalid; status_next = status; inserted_next = inserted;
    out_key_next = out_key; out_value_next = out_value; entry_count_next = entry_count;
    b_we = 1'b0; b_wa = '0; b_wd = '0; b_ra = cur;
    e_we = 1'b0; e_wa = '0; e_wd = '0; e_ra = '0;

    if (ovalid && !out_stall) begin
      ovalid_next = 1'b0;
    end

    case (st)
      S_CLR: begin
        b_we = 1'b1;
        b_wa = clr;
        clr_next = clr + 1'b1;
        if (clr == bidx_t'(CAPACITY - 1)) begin
          st_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          act_next = action; k_next = key; v_next = value; posr_next = position;
          hsh_next = hash; rem_next = '0; mc_next = '0;
          stat_next = cht_pkg::ST_OK; ins_next = 1'b0; ok_next = '0; ov_next = '0;
          st_next = S_MOD;
        end
      end
      S_MOD: begin
        rem_next = mod_r;
        hsh_next = hsh << cht_pkg::MOD_BITS;
        mc_next = mc + 1'b1;
        if (mc == MCW'(MODSTEPS - 1)) begin
          home_next = mod_r[BW-1:0];
          if (act == cht_pkg::ACT_READ) begin
            if (posr >= cnt_t'(1) && posr <= cnt) begin
              e_ra = bidx_t'(posr - 1'b1);
              st_next = S_RD;
            end else begin
              stat_next = cht_pkg::ST_RANGE;
              st_next = S_FIN;
            end
          end else begin
            b_ra = mod_r[BW-1:0];
            cur_next = mod_r[BW-1:0];
            prv_next = '0;
            steps_next = '0;
            st_next = S_LB;
          end
        end
      end
      S_RD: begin
        ok_next = re_key; ov_next = re_val;
        st_next = S_FIN;
      end
      S_LB, S_LE: begin
        if (st == S_LB && rb_ent != '0 && rb_ent <= CAP_C) begin
          e_next = rb_ent; n_next = rb_nxt;
          e_ra = bidx_t'(rb_ent - 1'b1);
          st_next = S_LE;
        end else if (st == S_LE && re_key == k) begin
          at_next = cur;
          if (act == cht_pkg::ACT_GET) begin
            ok_next = re_key; ov_next = re_val;
            st_next = S_FIN;
          end else if (act == cht_pkg::ACT_SET) begin
            e_we = 1'b1; e_wa = bidx_t'(e - 1'b1); e_wd = {k, v, re_home};
            ok_next = k; ov_next = v;
            st_next = S_FIN;
          end else begin
            ok_next = re_key; ov_next = re_val;
            if (e != cnt && cnt != '0) begin
              e_ra = bidx_t'(cnt - 1'b1);
              st_next = S_RL;
            end else begin
              if (cnt != '0) cnt_next = cnt - 1'b1;
              b_ra = cur;
              st_next = S_U1;
            end
          end
        end else if (st == S_LE && n != '0 && n <= CAP_C && steps != CAPM1_C) begin
          prv_next = cnt_t'(cur) + 1'b1;
          cur_next = bidx_t'(n - 1'b1);
          b_ra = bidx_t'(n - 1'b1);
          steps_next = steps + 1'b1;
          st_next = S_LB;
        end else begin
          if (act == cht_pkg::ACT_SET) begin
            if (cnt >= CAP_C) begin
              stat_next = cht_pkg::ST_FULL;
              st_next = S_FIN;
            end else begin
              e_we = 1'b1; e_wa = bidx_t'(cnt); e_wd = {k, v, home};
              b_ra = home;
              st_next = S_PH;
            end
          end else begin
            stat_next = cht_pkg::ST_NOTFOUND;
            st_next = S_FIN;
          end
        end
      end
      S_RL: begin
        last_ent_next = e_rd;
        cur_next = re_home;
        b_ra = re_home;
        steps_next = '0;
        st_next = S_RW;
      end
      S_RW: begin
        if (rb_ent == cnt) begin
          b_we = 1'b1; b_wa = cur; b_wd = {e, rb_nxt};
          st_next = S_RC;
        end else if (rb_nxt == '0 || rb_nxt > CAP_C || steps == CAPM1_C) begin
          st_next = S_RC;
        end else begin
          cur_next = bidx_t'(rb_nxt - 1'b1);
          b_ra = bidx_t'(rb_nxt - 1'b1);
          steps_next = steps + 1'b1;
        end
      end
      S_RC: begin
        e_we = 1'b1; e_wa = bidx_t'(e - 1'b1); e_wd = last_ent;
        cnt_next = cnt - 1'b1;
        b_ra = at;
        st_next = S_U1;
      end
      S_U1: begin
        n_next = rb_nxt;
        if (prv != '0) begin
          b_ra = bidx_t'(prv - 1'b1);
          st_next = S_U2;
        end else if (rb_nxt != '0 && rb_nxt <= CAP_C) begin
          b_ra = bidx_t'(rb_nxt - 1'b1);
          st_next = S_U3;
        end else begin
          slot_next = cnt_t'(at) + 1'b1;
          st_next = S_UC;
        end
      end
      S_U2: begin
        b_we = 1'b1; b_wa = bidx_t'(prv - 1'b1); b_wd = {rb_ent, n};
        slot_next = cnt_t'(at) + 1'b1;
        st_next = S_UC;
      end
      S_U3: begin
        b_we = 1'b1; b_wa = at; b_wd = b_rd;
        slot_next = n;
        st_next = S_UC;
      end
      S_UC: begin
        b_we = 1'b1; b_wa = bidx_t'(slot - 1'b1);
        if (slot > fp) fp_next = slot;
        st_next = S_FIN;
      end
      S_PH: begin
        if (rb_ent == '0) begin
          b_we = 1'b1; b_wa = home; b_wd = {cnt + 1'b1, cnt_t'(0)};
          cnt_next = cnt + 1'b1;
          ins_next = 1'b1; ok_next = k; ov_next = v;
          st_next = S_FIN;
        end else begin
          he_next = rb_ent; hn_next = rb_nxt;
          if (fp == '0) begin
            stat_next = cht_pkg::ST_FULL;
            st_next = S_FIN;
          end else begin
            b_ra = bidx_t'(fp - 1'b1);
            st_next = S_FS;
          end
        end
      end
      S_FS: begin
        if (rb_ent == '0) begin
          slot_next = fp;
          e_ra = bidx_t'(he - 1'b1);
          st_next = S_PO;
        end else begin
          fp_next = fp - 1'b1;
          if (fp == cnt_t'(1)) begin
            stat_next = cht_pkg::ST_FULL;
            st_next = S_FIN;
          end else begin
            b_ra = bidx_t'(fp - 2'd2);
          end
        end
      end
      S_PO: begin
        diff_next = (re_home != home);
        cur_next = re_home;
        b_ra = re_home;
        steps_next = '0;
        st_next = S_PW;
      end
      S_PW: begin
        if ((diff && rb_nxt == cnt_t'(home) + 1'b1) || rb_nxt == '0 || rb_nxt > CAP_C
            || steps == CAP_C) begin
          b_we = 1'b1; b_wa = cur; b_wd = {rb_ent, slot};
          st_next = S_P2;
        end else begin
          cur_next = bidx_t'(rb_nxt - 1'b1);
          b_ra = bidx_t'(rb_nxt - 1'b1);
          steps_next = steps + 1'b1;
        end
      end
      S_P2, S_P3: begin
        b_we = 1'b1;
        if (st == S_P2 && diff) begin
          b_wa = bidx_t'(slot - 1'b1); b_wd = {he, hn};
          st_next = S_P3;
        end else begin
          b_wa = (st == S_P3) ? home : bidx_t'(slot - 1'b1);
          b_wd = {cnt + 1'b1, cnt_t'(0)};
          fp_next = slot - 1'b1;
          cnt_next = cnt + 1'b1;
          ins_next = 1'b1; ok_next = k; ov_next = v;
          st_next = S_FIN;
        end
      end
      S_FIN: begin
        if (!ovalid || !out_stall) begin
          ovalid_next = 1'b1;
          status_next = stat; inserted_next = ins;
          out_key_next = ok; out_value_next = ov; entry_count_next = cnt;
          st_next = S_IDLE;
        end
      end
      default: begin
        st_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_CLR; clr <= '0; cnt <= '0; fp <= CAP_C; ovalid <= 1'b0;
    end else begin
      st <= st_next; clr <= clr_next; cnt <= cnt_next; fp <= fp_next;
      ovalid <= ovalid_next;
    end
  end

  always_ff @(posedge clk) begin
    hsh <= hsh_next; rem <= rem_next; mc <= mc_next; act <= act_next;
    k <= k_next; v <= v_next; posr <= posr_next; home <= home_next;
    cur <= cur_next; at <= at_next; prv <= prv_next; e <= e_next; n <= n_next;
    steps <= steps_next; he <= he_next; hn <= hn_next; slot <= slot_next;
    diff <= diff_next; last_ent <= last_ent_next; stat <= stat_next;
    ins <= ins_next; ok <= ok_next; ov <= ov_next;
    status <= status_next; inserted <= inserted_next; out_key <= out_key_next;
    out_value <= out_value_next; entry_count <= entry_count_next;
  end

`include "coalesced_hash_table_top_assert.svh"

  `CHT_IMPLY(a_count_bound, 1'b1, cnt <= CAP_C && fp <= CAP_C, "count past capacity")
  `CHT_IMPLY(a_clear_stall, st == S_CLR, in_stall, "request taken during clear")
  `CHT_NEXT(a_accept_mod, accept, st == S_MOD, "accepted request not reduced")
  `CHT_NEXT(a_fin_out, st == S_FIN && !(ovalid && out_stall), out_valid && st == S_IDLE, "no result")

endmodule

[hdl/cht_ram.sv]
// Generic single-write, single-read RAM with registered read data
module cht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
